// ===== sv/brb_pkg.sv =====
// ============================================================================
// brb_pkg: shared definitions for the broadcast ring buffer
// Sizes, operation codes, controller states and the command and status
// bundles that join the controller and the datapath.
// ============================================================================
package brb_pkg;

	// Store and reader sizing.
	localparam int BUF_BYTES = 1024;
	localparam int PTR_W     = $clog2(BUF_BYTES);
	localparam int CNT_W     = PTR_W + 1;
	localparam int READERS   = 8;
	localparam int IDX_W     = 3;
	localparam int LAP_W     = 8;
	localparam int CLI_W     = 8;

	// Stream widths.
	localparam int S_DATA_W = 8;
	localparam int S_USER_W = 5;
	localparam int M_DATA_W = 24;
	localparam int M_USER_W = 2;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_READ,
		OP_OPEN,
		OP_RELEASE
	} brb_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_REPORT
	} brb_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic execute;
		logic report;
	} brb_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
	} brb_stat_t;

endpackage

// ===== sv/brb_ctrl.sv =====
// ============================================================================
// brb_ctrl: request sequencer for the broadcast ring buffer
// Takes one request, lets the datapath execute it, then loads its result
// into the output register as soon as that register is free.
// ============================================================================
module brb_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  brb_pkg::brb_stat_t stat,
	output brb_pkg::brb_cmd_t  cmd
);
	import brb_pkg::*;

	brb_state_t state_q;
	brb_state_t state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				state_nxt = ST_REPORT;
			end
			ST_REPORT: begin
				if (stat.out_free) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Outputs.
	always_comb begin
		s_tready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		cmd.report  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
			end
			ST_EXEC: begin
				cmd.execute = 1'b1;
			end
			ST_REPORT: begin
				cmd.report = stat.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

// ===== sv/brb_dp.sv =====
// ============================================================================
// brb_dp: datapath of the broadcast ring buffer
// Holds the byte store, the writer and reader pointers, the client counts
// and the output register, and carries out one request per command.
// ============================================================================
module brb_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  brb_pkg::brb_cmd_t              cmd,
	output brb_pkg::brb_stat_t             stat,
	input  logic [brb_pkg::S_DATA_W-1:0]   s_tdata,
	input  logic [brb_pkg::S_USER_W-1:0]   s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [brb_pkg::M_DATA_W-1:0]   m_tdata,
	output logic [brb_pkg::M_USER_W-1:0]   m_tuser
);
	import brb_pkg::*;

	// Unread bytes of one reader against the writer.
	function automatic logic [CNT_W-1:0] unread_of(
		input logic [PTR_W-1:0] wp,
		input logic [LAP_W-1:0] wl,
		input logic [PTR_W-1:0] rp,
		input logic [LAP_W-1:0] rl,
		input logic [CLI_W-1:0] cc
	);
		logic [LAP_W-1:0] d;
		logic [CNT_W-1:0] n;
		d = wl - rl;
		n = CNT_W'(BUF_BYTES) - {1'b0, rp} + {1'b0, wp};
		if (cc == '0) begin
			unread_of = '0;
		end else if (d == '0) begin
			unread_of = (wp >= rp) ? ({1'b0, wp} - {1'b0, rp}) : '0;
		end else if (d == LAP_W'(1)) begin
			unread_of = (n > CNT_W'(BUF_BYTES)) ? CNT_W'(BUF_BYTES) : n;
		end else begin
			unread_of = CNT_W'(BUF_BYTES);
		end
	endfunction

	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUF_BYTES - 1);

	// Captured request.
	brb_op_t           op_q;
	logic [IDX_W-1:0]  idx_q;
	logic [7:0]        din_q;

	// Pointer state.
	logic [PTR_W-1:0]  wpos_q;
	logic [LAP_W-1:0]  wlap_q;
	logic              wwrap_q;
	logic [PTR_W-1:0]  rpos_q [READERS];
	logic [LAP_W-1:0]  rlap_q [READERS];
	logic [CLI_W-1:0]  ccnt_q [READERS];

	// Store and read path.
	logic [7:0]        store_q [BUF_BYTES];
	logic [7:0]        rd_q;
	logic              hit_q;

	// Output register.
	logic              ovalid_q;
	logic [7:0]        odata_q;
	logic              ohit_q;
	logic [CNT_W-1:0]  ounread_q;
	logic              oopen_q;

	logic [READERS-1:0] full;
	logic [CNT_W-1:0]   sel_unread;

	// Per-reader full flags, compared in parallel.
	always_comb begin
		for (int i = 0; i < READERS; i++) begin
			full[i] = unread_of(wpos_q, wlap_q, rpos_q[i], rlap_q[i], ccnt_q[i])
				== CNT_W'(BUF_BYTES);
		end
	end

	assign sel_unread = unread_of(wpos_q, wlap_q, rpos_q[idx_q], rlap_q[idx_q],
		ccnt_q[idx_q]);

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= brb_op_t'(s_tuser[1:0]);
			idx_q <= s_tuser[IDX_W+1:2];
			din_q <= s_tdata[7:0];
		end
	end

	// Byte store: one write or one registered read per request.
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			if (op_q == OP_WRITE) begin
				store_q[wpos_q] <= din_q;
			end else begin
				rd_q <= store_q[rpos_q[idx_q]];
			end
		end
	end

	// Pointer and client count updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q  <= '0;
			wlap_q  <= '0;
			wwrap_q <= 1'b0;
			hit_q   <= 1'b0;
			for (int i = 0; i < READERS; i++) begin
				rpos_q[i] <= '0;
				rlap_q[i] <= '0;
				ccnt_q[i] <= '0;
			end
		end else if (cmd.execute) begin
			hit_q <= 1'b0;
			case (op_q)
				OP_WRITE: begin
					// Readers that are a full store behind lose their oldest byte.
					for (int i = 0; i < READERS; i++) begin
						if (full[i]) begin
							if (rpos_q[i] == PTR_LAST) begin
								rpos_q[i] <= '0;
								rlap_q[i] <= rlap_q[i] + LAP_W'(1);
							end else begin
								rpos_q[i] <= rpos_q[i] + PTR_W'(1);
							end
						end
					end
					if (wpos_q == PTR_LAST) begin
						wpos_q  <= '0;
						wlap_q  <= wlap_q + LAP_W'(1);
						wwrap_q <= 1'b1;
					end else begin
						wpos_q <= wpos_q + PTR_W'(1);
					end
				end
				OP_READ: begin
					if (sel_unread != '0) begin
						hit_q <= 1'b1;
						if (rpos_q[idx_q] == PTR_LAST) begin
							rpos_q[idx_q] <= '0;
							rlap_q[idx_q] <= rlap_q[idx_q] + LAP_W'(1);
						end else begin
							rpos_q[idx_q] <= rpos_q[idx_q] + PTR_W'(1);
						end
					end
				end
				OP_OPEN: begin
					rpos_q[idx_q] <= wpos_q;
					rlap_q[idx_q] <= wlap_q - LAP_W'(wwrap_q);
					if (ccnt_q[idx_q] != '1) begin
						ccnt_q[idx_q] <= ccnt_q[idx_q] + CLI_W'(1);
					end
				end
				default: begin
					// Release; the last client parks the reader at the origin.
					if (ccnt_q[idx_q] != '0) begin
						ccnt_q[idx_q] <= ccnt_q[idx_q] - CLI_W'(1);
						if (ccnt_q[idx_q] == CLI_W'(1)) begin
							rpos_q[idx_q] <= '0;
							rlap_q[idx_q] <= '0;
						end
					end
				end
			endcase
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.report) begin
			ovalid_q <= 1'b1;
		end else if (m_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	// Output register payload, taken from the state after the request.
	always_ff @(posedge clk) begin
		if (cmd.report) begin
			odata_q   <= hit_q ? rd_q : 8'd0;
			ohit_q    <= hit_q;
			ounread_q <= sel_unread;
			oopen_q   <= (ccnt_q[idx_q] != '0);
		end
	end

	assign stat.out_free = !ovalid_q || m_tready;
	assign m_tvalid      = ovalid_q;
	assign m_tdata       = {(M_DATA_W - 8 - CNT_W)'(0), ounread_q, odata_q};
	assign m_tuser       = {oopen_q, ohit_q};

	// A delivered byte only ever comes from a read request.
	a_hit_is_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.report && hit_q |-> op_q == OP_READ)
		else $error("byte delivered for a request that is not a read");

	// A reader without clients sits at the origin.
	a_closed_parked: assert property (@(posedge clk) disable iff (!arst_n)
		ccnt_q[idx_q] == '0 |-> rpos_q[idx_q] == '0 && rlap_q[idx_q] == '0)
		else $error("closed reader has a nonzero position or lap");

	// The reported count never exceeds the store size.
	a_unread_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q |-> ounread_q <= CNT_W'(BUF_BYTES))
		else $error("unread count above store size");

	// The writer cannot have a nonzero lap without having wrapped.
	a_wrap_flag: assert property (@(posedge clk) disable iff (!arst_n)
		wlap_q != '0 |-> wwrap_q)
		else $error("writer lap advanced without wrap flag");

endmodule

// ===== sv/broadcast_ring_buffer.sv =====
// ============================================================================
// broadcast_ring_buffer: one writer, eight readers over a 1024-byte ring
// Each request writes, reads, opens or releases a reader and returns one
// result describing the selected reader after the request.
// ============================================================================
// Every request passes three steps from acceptance to a loaded result:
// capture, then the pointer update and the access to the single-port
// byte store, whose read data is registered, then the load of the output
// register, which waits while the output is stalled. The next request is
// accepted while the previous result still waits in the output register.
// The store holds no reset value: reading a byte that was never written
// returns an unspecified value.
module broadcast_ring_buffer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [brb_pkg::S_DATA_W-1:0]   s_tdata,  // [7:0] data_in
	input  logic [brb_pkg::S_USER_W-1:0]   s_tuser,  // [1:0] operation, [4:2] reader_index
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [brb_pkg::M_DATA_W-1:0]   m_tdata,  // [7:0] data_out, [18:8] unread_count
	output logic [brb_pkg::M_USER_W-1:0]   m_tuser   // [0] data_valid, [1] reader_open
);
	import brb_pkg::*;

	brb_cmd_t  cmd;
	brb_stat_t stat;

	// Request sequencer.
	brb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Store, pointers and output register.
	brb_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
